// ===== rtl/rse_pkg.sv =====
package rse_pkg;

    typedef enum logic [2:0] {
        KIND_NUMBER = 3'd0,
        KIND_ADD    = 3'd1,
        KIND_SUB    = 3'd2,
        KIND_MUL    = 3'd3,
        KIND_DIV    = 3'd4,
        KIND_REM    = 3'd5,
        KIND_PRINT  = 3'd6,
        KIND_UNK    = 3'd7
    } kind_t;

    localparam logic [63:0] SIGN_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] POS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] operand_value;
    } token_t;

    typedef struct packed {
        logic [63:0] result_value;
        logic        result_valid;
        logic        stack_underflow;
        logic        stack_overflow;
        logic        zero_divisor;
        logic        unknown_command;
    } result_t;

    // Apply a sign to a magnitude and saturate; big means magnitude >= 2^64.
    function automatic logic [63:0] signed_sat(input logic neg, input logic [63:0] mag,
                                               input logic big);
        logic [63:0] r;
        if (!neg)
            r = (big || mag > POS_MAX) ? POS_MAX : mag;
        else
            r = (big || mag > SIGN_MIN) ? SIGN_MIN : (64'd0 - mag);
        return r;
    endfunction

    function automatic logic [63:0] mag64(input logic [63:0] x);
        return x[63] ? (64'd0 - x) : x;
    endfunction

endpackage

// ===== rtl/rse_if.sv =====
interface rse_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/rse_front.sv =====
// Accept tokens and hold them in a short queue for the execution unit.
module rse_front (
    input  logic clk,
    input  logic rst_n,
    rse_if.sink  in_ch,
    output logic q_valid,
    output rse_pkg::token_t q_data,
    input  logic q_pop
);
    import rse_pkg::*;

    localparam int QD = 4;

    token_t     fifo_reg [QD];
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] cnt_reg;
    logic       push;

    assign in_ch.ready = (cnt_reg != 3'(QD));
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (cnt_reg != 3'd0);
    assign q_data      = fifo_reg[rd_reg];

    // Store a transferred token.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_reg] <= in_ch.data;
        end
    end

    // Advance queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 2'd1;
            if (q_pop)
                rd_reg <= rd_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(push) - 3'(q_pop);
        end
    end

endmodule

// ===== rtl/rse_back.sv =====
// Execute tokens against the operand stack; one radix-2 step per cycle for divide.
module rse_back #(
    parameter int STACK_DEPTH = 1024
) (
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    input  rse_pkg::token_t q_data,
    output logic q_pop,
    rse_if.source out_ch
);
    import rse_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_RDB, S_WB, S_RDA, S_WA, S_MUL, S_MULS, S_DIV, S_FIN, S_PUSH, S_OUT
    } state_t;

    state_t       state_reg;
    logic [63:0]  mem [STACK_DEPTH];
    logic [63:0]  rd_data_reg;
    logic [CW-1:0] count_reg;
    logic [2:0]   kind_reg;
    logic [63:0]  a_reg, b_reg, res_reg;
    logic         under_reg, over_reg, zdiv_reg;
    logic         neg_reg, big_reg;
    logic [63:0]  hh_reg, t1_reg, t2_reg, t3_reg;
    logic [127:0] dvd_reg;
    logic [63:0]  rem_reg;
    logic [63:0]  quo_reg, dsr_reg;
    logic [6:0]   step_reg;
    logic         rd_en;
    logic [AW-1:0] rd_addr;
    logic         wr_en;
    logic [AW-1:0] wr_addr;
    logic [63:0]  wr_data;
    logic [63:0]  ma, mb, mrd;
    logic [63:0]  pl;
    logic [64:0]  rsh, rtry;
    logic [64:0]  s1, s2, s3;
    logic [63:0]  addv, subv, pushv;

    assign rd_addr = AW'(count_reg - CW'(1));
    assign wr_addr = AW'(count_reg);
    assign q_pop   = (state_reg == S_IDLE) && q_valid;
    assign out_ch.valid = (state_reg == S_OUT);

    // Stack memory with registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign ma = mag64(a_reg);
    assign mb = mag64(b_reg);
    assign mrd = mag64(rd_data_reg);
    assign pl = ma[31:0] * mb[31:0];
    assign rsh  = {rem_reg, dvd_reg[127]};
    assign rtry = rsh - {1'b0, dsr_reg};
    assign s1 = {1'b0, hh_reg[31:0], 32'd0} + {1'b0, t1_reg};
    assign s2 = {1'b0, s1[63:0]} + {1'b0, t2_reg};
    assign s3 = {1'b0, s2[63:0]} + {1'b0, t3_reg};
    assign addv = a_reg + b_reg;
    assign subv = a_reg - b_reg;

    // Pushed value: the number, saturated add or subtract, else res_reg.
    always_comb
    begin
        pushv = res_reg;
        case (kind_reg)
            KIND_ADD:
                pushv = ((a_reg[63] == b_reg[63]) && (addv[63] != a_reg[63]))
                        ? (a_reg[63] ? SIGN_MIN : POS_MAX) : addv;
            KIND_SUB:
                pushv = ((a_reg[63] != b_reg[63]) && (subv[63] != a_reg[63]))
                        ? (a_reg[63] ? SIGN_MIN : POS_MAX) : subv;
            KIND_NUMBER:
                pushv = a_reg;
            default:
                pushv = res_reg;
        endcase
    end

    assign rd_en = ((state_reg == S_RDB) || (state_reg == S_RDA)) && (count_reg != '0);
    assign wr_en = (state_reg == S_PUSH) && (count_reg != CW'(STACK_DEPTH));
    assign wr_data = pushv;

    // Hold state, operands and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (q_valid)
                    begin
                        kind_reg  <= q_data.kind;
                        a_reg     <= q_data.operand_value;
                        res_reg   <= '0;
                        under_reg <= 1'b0;
                        over_reg  <= 1'b0;
                        zdiv_reg  <= 1'b0;
                        case (kind_t'(q_data.kind))
                            KIND_NUMBER: state_reg <= S_PUSH;
                            KIND_UNK:    state_reg <= S_OUT;
                            default:     state_reg <= S_RDB;
                        endcase
                    end
                S_RDB:
                begin
                    if (count_reg == '0)
                        under_reg <= 1'b1;
                    else
                        count_reg <= count_reg - CW'(1);
                    state_reg <= S_WB;
                end
                S_WB:
                begin
                    b_reg <= under_reg ? 64'd0 : rd_data_reg;
                    if (kind_reg == KIND_PRINT)
                    begin
                        res_reg   <= under_reg ? 64'd0 : rd_data_reg;
                        state_reg <= S_OUT;
                    end
                    else if ((kind_reg == KIND_DIV && (under_reg || rd_data_reg == 64'd0)) ||
                             (kind_reg == KIND_REM &&
                              (under_reg || mrd[63:32] == 32'd0)))
                    begin
                        zdiv_reg  <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_RDA;
                end
                S_RDA:
                begin
                    if (count_reg == '0)
                        under_reg <= 1'b1;
                    else
                        count_reg <= count_reg - CW'(1);
                    state_reg <= S_WA;
                end
                S_WA:
                begin
                    a_reg <= under_reg ? 64'd0 : rd_data_reg;
                    if (kind_reg == KIND_MUL)
                        state_reg <= S_MUL;
                    else if (kind_reg == KIND_DIV || kind_reg == KIND_REM)
                        state_reg <= S_DIV;
                    else
                        state_reg <= S_PUSH;
                end
                S_MUL:
                begin
                    neg_reg <= a_reg[63] ^ b_reg[63];
                    hh_reg  <= ma[63:32] * mb[63:32];
                    t1_reg  <= ma[63:32] * mb[31:0];
                    t2_reg  <= ma[31:0] * mb[63:32];
                    t3_reg  <= {32'd0, pl[63:32]};
                    state_reg <= S_MULS;
                end
                S_MULS:
                begin
                    res_reg <= signed_sat(neg_reg, s3[63:0],
                                          (hh_reg[63:32] != 32'd0) || s1[64] || s2[64] || s3[64]);
                    state_reg <= S_PUSH;
                end
                S_DIV:
                begin
                    // Load the dividend shift register and divisor.
                    if (kind_reg == KIND_DIV)
                    begin
                        neg_reg  <= a_reg[63] ^ b_reg[63];
                        dvd_reg  <= {32'd0, ma, 32'd0};
                        dsr_reg  <= mb;
                        step_reg <= 7'd127;
                    end
                    else
                    begin
                        neg_reg  <= a_reg[63];
                        dvd_reg  <= {ma[63:32], 96'd0};
                        dsr_reg  <= {32'd0, mb[63:32]};
                        step_reg <= 7'd31;
                    end
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    big_reg   <= 1'b0;
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    // One restoring-division step per cycle.
                    dvd_reg <= {dvd_reg[126:0], 1'b0};
                    if (!rtry[64])
                        rem_reg <= rtry[63:0];
                    else
                        rem_reg <= rsh[63:0];
                    if (quo_reg[63])
                        big_reg <= 1'b1;
                    quo_reg <= {quo_reg[62:0], !rtry[64]};
                    step_reg <= step_reg - 7'd1;
                    if (step_reg == 7'd0)
                    begin
                        if (kind_reg == KIND_DIV)
                            res_reg <= signed_sat(neg_reg, {quo_reg[62:0], !rtry[64]},
                                                  big_reg || quo_reg[63]);
                        else
                            res_reg <= neg_reg
                                ? (64'd0 - {(!rtry[64] ? rtry[31:0] : rsh[31:0]), 32'd0})
                                : {(!rtry[64] ? rtry[31:0] : rsh[31:0]), 32'd0};
                        state_reg <= S_PUSH;
                    end
                end
                S_PUSH:
                begin
                    if (count_reg == CW'(STACK_DEPTH))
                        over_reg <= 1'b1;
                    else
                        count_reg <= count_reg + CW'(1);
                    res_reg   <= '0;
                    state_reg <= S_OUT;
                end
                S_OUT:
                    if (out_ch.ready)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_ch.data.result_value    = (kind_reg == KIND_PRINT) ? res_reg : 64'd0;
    assign out_ch.data.result_valid    = (kind_reg == KIND_PRINT);
    assign out_ch.data.stack_underflow = under_reg;
    assign out_ch.data.stack_overflow  = over_reg;
    assign out_ch.data.zero_divisor    = zdiv_reg;
    assign out_ch.data.unknown_command = (kind_reg == KIND_UNK);

endmodule

// ===== rtl/rpn_stack_evaluator_top.sv =====
// Channel   Dir  Payload
// in_ch     in   kind, operand_value (token_t)
// out_ch    out  result_value, flags (result_t)
//
// Each token pops its operands, computes and pushes; a number only pushes, a print only pops
// and an unknown token only reports; a zero divisor stops after the divisor pop.
// Divide and remainder run a one-bit-per-cycle restoring loop.
// The output holds each result until ready, which stalls the next token.
// Reset clears the stack count; stack contents are undefined until written.
// A four-entry token queue keeps accepting, until full, while the execution unit or output stalls.
module rpn_stack_evaluator_top #(
    parameter int STACK_DEPTH = 1024
) (
    input logic clk,
    input logic rst_n,
    rse_if.sink   in_ch,
    rse_if.source out_ch
);
    import rse_pkg::*;

    logic   q_valid, q_pop;
    token_t q_data;

    rse_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
    );

    rse_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data),
        .q_pop(q_pop), .out_ch(out_ch)
    );

    a_print_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.data.result_valid |-> !out_ch.data.unknown_command)
        else $error("print result flagged unknown");
    a_pop_needs_queue: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty token queue");

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    import rse_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rse_if #(.T(token_t))  tok_ch ();
    rse_if #(.T(result_t)) res_ch ();

    rpn_stack_evaluator_top #(.STACK_DEPTH(1024)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (tok_ch.sink),
        .out_ch (res_ch.source)
    );

    localparam int DEPTH = 1024;

    // toggle the clock every half period
    always #5 clk = ~clk;

    token_t  token_q[$];
    result_t expected_q[$];

    // evaluator state mirrored in the testbench
    logic [63:0] shadow_stack[DEPTH];
    int unsigned shadow_count;
    logic        pop_empty;
    logic        push_full;

    int     error_count = 0;
    int     tokens_sent = 0;
    int     prints_seen = 0;
    int     results_seen = 0;
    bit     calm = 1'b0;
    bit     hold_off = 1'b0;
    bit     tok_taken = 1'b0;

    function automatic logic [63:0] stack_pop();
        if (shadow_count > 0)
        begin
            shadow_count--;
            return shadow_stack[shadow_count];
        end
        pop_empty = 1'b1;
        return 64'd0;
    endfunction

    function automatic void stack_push(input logic [63:0] v);
        if (shadow_count < DEPTH)
        begin
            shadow_stack[shadow_count] = v;
            shadow_count++;
        end
        else
            push_full = 1'b1;
    endfunction

    function automatic logic [63:0] abs_val(input logic [63:0] x);
        return x[63] ? (64'd0 - x) : x;
    endfunction

    function automatic logic [63:0] clamp_signed(input logic neg, input logic [127:0] m);
        if (!neg)
            return (m > {64'd0, POS_MAX}) ? POS_MAX : m[63:0];
        return (m > {64'd0, SIGN_MIN}) ? SIGN_MIN : (64'd0 - m[63:0]);
    endfunction

    function automatic logic [63:0] sum_sat(input logic [63:0] a, input logic [63:0] b,
                                             input logic negate_b);
        logic signed [64:0] s;
        if (negate_b)
            s = $signed({a[63], a}) - $signed({b[63], b});
        else
            s = $signed({a[63], a}) + $signed({b[63], b});
        if (s > $signed({1'b0, POS_MAX}))
            return POS_MAX;
        if (s < $signed({1'b1, SIGN_MIN}))
            return SIGN_MIN;
        return s[63:0];
    endfunction

    function automatic logic [63:0] fixed_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, abs_val(a)} * {64'd0, abs_val(b)};
        return clamp_signed(a[63] ^ b[63], p >> 32);
    endfunction

    function automatic logic [63:0] fixed_div(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] q;
        q = ({64'd0, abs_val(a)} << 32) / {64'd0, abs_val(b)};
        return clamp_signed(a[63] ^ b[63], q);
    endfunction

    // evaluate one token against the shadow stack
    function automatic result_t evaluate_token(input token_t t);
        result_t r;
        logic [63:0] a, b, rm, ma, mb;
        logic [31:0] da, db;
        r = '0;
        pop_empty = 1'b0;
        push_full = 1'b0;
        case (kind_t'(t.kind))
            KIND_NUMBER: stack_push(t.operand_value);
            KIND_ADD:
            begin
                b = stack_pop(); a = stack_pop();
                stack_push(sum_sat(a, b, 1'b0));
            end
            KIND_SUB:
            begin
                b = stack_pop(); a = stack_pop();
                stack_push(sum_sat(a, b, 1'b1));
            end
            KIND_MUL:
            begin
                b = stack_pop(); a = stack_pop();
                stack_push(fixed_mul(a, b));
            end
            KIND_DIV:
            begin
                b = stack_pop();
                if (b == 64'd0)
                    r.zero_divisor = 1'b1;
                else
                begin
                    a = stack_pop();
                    stack_push(fixed_div(a, b));
                end
            end
            KIND_REM:
            begin
                b = stack_pop();
                mb = abs_val(b);
                db = mb[63:32];
                if (db == 32'd0)
                    r.zero_divisor = 1'b1;
                else
                begin
                    a = stack_pop();
                    ma = abs_val(a);
                    da = ma[63:32];
                    rm = {da % db, 32'd0};
                    stack_push(a[63] ? (64'd0 - rm) : rm);
                end
            end
            KIND_PRINT:
            begin
                r.result_value = stack_pop();
                r.result_valid = 1'b1;
            end
            default: r.unknown_command = 1'b1;
        endcase
        r.stack_underflow = pop_empty;
        r.stack_overflow  = push_full;
        return r;
    endfunction

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: v = SIGN_MIN;
            1: v = POS_MAX;
            2: v = 64'd0;
            3: v = {{32{v[63]}}, v[31:0]};
            4: v = {v[63:32], 32'd0};
            5: v = {{24{v[39]}}, v[39:0]};
            default: ;
        endcase
        return v;
    endfunction

    function automatic token_t make_token(input kind_t k, input logic [63:0] v);
        token_t t;
        t.kind = k;
        t.operand_value = v;
        return t;
    endfunction

    // driver: present the head of the pending queue, idle at random
    always @(negedge clk)
    begin
        if (!rst_n)
            tok_ch.valid <= 1'b0;
        else if (tok_ch.valid && !tok_taken)
            ;
        else if (token_q.size() > 0 && (calm || $urandom_range(0, 99) >= 15))
        begin
            tok_ch.data  <= token_q[0];
            tok_ch.valid <= 1'b1;
        end
        else
            tok_ch.valid <= 1'b0;
    end

    // pop the pending queue and predict on each accepted transfer
    always @(posedge clk)
    begin
        tok_taken = rst_n && tok_ch.valid && tok_ch.ready;
        if (tok_taken)
        begin
            expected_q.push_back(evaluate_token(token_q.pop_front()));
            tokens_sent++;
        end
    end

    // receiver stalls at random, or for a long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= !hold_off && (calm || $urandom_range(0, 99) >= 15);
    end

    // monitor: compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            results_seen++;
            if (res_ch.data.result_valid)
                prints_seen++;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, res_ch.data);
                error_count++;
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (res_ch.data.result_value !== exp_r.result_value)
                begin
                    $display("%0t: result_value expected %h actual %h", $time,
                             exp_r.result_value, res_ch.data.result_value);
                    error_count++;
                end
                if (res_ch.data.result_valid !== exp_r.result_valid)
                begin
                    $display("%0t: result_valid expected %b actual %b", $time,
                             exp_r.result_valid, res_ch.data.result_valid);
                    error_count++;
                end
                if (res_ch.data.stack_underflow !== exp_r.stack_underflow)
                begin
                    $display("%0t: stack_underflow expected %b actual %b", $time,
                             exp_r.stack_underflow, res_ch.data.stack_underflow);
                    error_count++;
                end
                if (res_ch.data.stack_overflow !== exp_r.stack_overflow)
                begin
                    $display("%0t: stack_overflow expected %b actual %b", $time,
                             exp_r.stack_overflow, res_ch.data.stack_overflow);
                    error_count++;
                end
                if (res_ch.data.zero_divisor !== exp_r.zero_divisor)
                begin
                    $display("%0t: zero_divisor expected %b actual %b", $time,
                             exp_r.zero_divisor, res_ch.data.zero_divisor);
                    error_count++;
                end
                if (res_ch.data.unknown_command !== exp_r.unknown_command)
                begin
                    $display("%0t: unknown_command expected %b actual %b", $time,
                             exp_r.unknown_command, res_ch.data.unknown_command);
                    error_count++;
                end
            end
        end
    end

    // hold off the receiver for a long stretch once the stimulus is under way
    initial
    begin
        int n;
        wait (tokens_sent >= 600);
        @(negedge clk);
        hold_off = 1'b1;
        for (n = 0; n < 300; n++)
            @(negedge clk);
        hold_off = 1'b0;
    end

    // overall time limit
    initial
    begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // stimulus and end of run
    initial
    begin
        int i, k, depth_goal;
        token_q = {};
        shadow_count = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty pops, each operation, extremes, zero divisors, unknown
        token_q.push_back(make_token(KIND_PRINT, 64'd0));
        token_q.push_back(make_token(KIND_ADD, 64'd0));
        token_q.push_back(make_token(KIND_NUMBER, POS_MAX));
        token_q.push_back(make_token(KIND_NUMBER, POS_MAX));
        token_q.push_back(make_token(KIND_ADD, 64'd0));
        token_q.push_back(make_token(KIND_NUMBER, SIGN_MIN));
        token_q.push_back(make_token(KIND_SUB, 64'd0));
        token_q.push_back(make_token(KIND_NUMBER, SIGN_MIN));
        token_q.push_back(make_token(KIND_MUL, 64'd0));
        token_q.push_back(make_token(KIND_NUMBER, 64'd0));
        token_q.push_back(make_token(KIND_DIV, 64'd0));
        token_q.push_back(make_token(KIND_NUMBER, 64'h0000_0000_8000_0000));
        token_q.push_back(make_token(KIND_REM, 64'd0));
        token_q.push_back(make_token(KIND_PRINT, 64'd0));
        token_q.push_back(make_token(KIND_NUMBER, SIGN_MIN));
        token_q.push_back(make_token(KIND_NUMBER, 64'hFFFF_FFFF_0000_0000));
        token_q.push_back(make_token(KIND_REM, 64'd0));
        token_q.push_back(make_token(KIND_PRINT, 64'd0));
        token_q.push_back(make_token(KIND_NUMBER, 64'hFFFF_FFFF_8000_0000));
        token_q.push_back(make_token(KIND_NUMBER, 64'h0000_0003_0000_0000));
        token_q.push_back(make_token(KIND_DIV, 64'd0));
        token_q.push_back(make_token(KIND_PRINT, 64'd0));
        token_q.push_back(make_token(KIND_UNK, 64'hFFFF_FFFF_FFFF_FFFF));
        token_q.push_back(make_token(KIND_PRINT, 64'd0));

        // fill the stack past its depth to reach overflow, then drain part of it
        for (i = 0; i < DEPTH + 3; i++)
            token_q.push_back(make_token(KIND_NUMBER, random_value()));
        token_q.push_back(make_token(KIND_ADD, 64'd0));
        for (i = 0; i < 40; i++)
            token_q.push_back(make_token(kind_t'($urandom_range(1, 6)), 64'd0));
        for (i = 0; i < 300; i++)
            token_q.push_back(make_token(KIND_PRINT, 64'd0));

        // random: mostly well-formed expressions, some noise
        calm = 1'b1;
        for (i = 0; i < 400; )
        begin
            if (i >= 150)
                calm = 1'b0;
            if ($urandom_range(0, 9) < 8)
            begin
                depth_goal = $urandom_range(1, 4);
                for (k = 0; k < depth_goal; k++)
                begin
                    token_q.push_back(make_token(KIND_NUMBER, random_value()));
                    i++;
                end
                for (k = 1; k < depth_goal; k++)
                begin
                    token_q.push_back(make_token(kind_t'($urandom_range(1, 5)),
                                                 {$urandom, $urandom}));
                    i++;
                end
                token_q.push_back(make_token(KIND_PRINT, 64'd0));
                i++;
            end
            else
            begin
                token_q.push_back(make_token(kind_t'($urandom_range(0, 7)), random_value()));
                i++;
            end
            while (token_q.size() > 64)
                @(posedge clk);
        end

        wait (token_q.size() == 0);
        wait (expected_q.size() == 0);
        repeat (200) @(posedge clk);

        $display("Sent %0d tokens, checked %0d results including %0d prints.",
                 tokens_sent, results_seen, prints_seen);
        $display("Covered underflow, full-stack overflow, saturation and zero divisors.");
        if (error_count == 0 && expected_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rse_pkg.sv
rtl/rse_if.sv
rtl/rse_front.sv
rtl/rse_back.sv
rtl/rpn_stack_evaluator_top.sv
test/tb_top.sv
